>>> rtl/lqs_pkg.sv
// lqs_pkg: shared types, constants and helper functions for the line quad setup block.
// Used by every module under rtl; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lqs_pkg;

    localparam int ONE_PIXEL  = 65536;
    localparam int HALF_PIXEL = 32768;

    localparam int LQS_X_OFFSET = 0;
    localparam int LQS_Y_OFFSET = 0;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MODE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_BIAS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_SCALE = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA       = 3'd7;

    localparam logic [1:0] DEPTH_CONST = 2'd0;
    localparam logic [1:0] DEPTH_VIEWZ = 2'd1;
    localparam logic [1:0] DEPTH_BIAS  = 2'd2;

    localparam logic [31:0] RST_CLIP_LEFT   = 32'd0;
    localparam logic [31:0] RST_CLIP_RIGHT  = 32'd41943040;
    localparam logic [31:0] RST_CLIP_TOP    = 32'd0;
    localparam logic [31:0] RST_CLIP_BOTTOM = 32'd31457280;
    localparam logic [1:0]  RST_DEPTH_MODE  = DEPTH_BIAS;
    localparam logic [24:0] RST_DEPTH_BIAS  = 25'd16861524;
    localparam logic [24:0] RST_DEPTH_SCALE = 25'd16861524;
    localparam logic [7:0]  RST_ALPHA       = 8'd255;

    localparam logic [24:0] DEPTH_ONE = 25'h1000000;

    typedef struct packed {
        logic signed [31:0] clip_left;
        logic signed [31:0] clip_right;
        logic signed [31:0] clip_top;
        logic signed [31:0] clip_bottom;
        logic [1:0]         depth_mode;
        logic [24:0]        depth_bias;
        logic [24:0]        depth_scale;
        logic [7:0]         alpha;
    } lqs_cfg_t;

    typedef struct packed {
        logic               xmajor;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic [24:0]        depth;
        logic [24:0]        rw;
        logic [31:0]        color;
        logic [31:0]        spec;
    } lqs_sorted_t;

    typedef struct packed {
        logic               xmajor;
        logic signed [33:0] x0;
        logic signed [33:0] y0;
        logic signed [33:0] x1;
        logic signed [33:0] y1;
        logic [24:0]        depth;
        logic [24:0]        rw;
        logic [31:0]        color;
        logic [31:0]        spec;
    } lqs_quad_t;

    function automatic logic signed [32:0] clamp_s33(
        input logic signed [32:0] v,
        input logic signed [32:0] lo,
        input logic signed [32:0] hi
    );
        logic signed [32:0] r;
        r = v;
        if (r < lo)
        begin
            r = lo;
        end
        if (r > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

    function automatic logic [31:0] sat_s32(input logic signed [34:0] v);
        logic [31:0] r;
        if (v > 35'sd2147483647)
        begin
            r = 32'h7FFF_FFFF;
        end
        else if (v < -35'sd2147483648)
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/lqs_sort.sv
// lqs_sort: first two pipeline stages - endpoint deltas and depth product, then
// major axis, endpoint ordering and depth clamp. Depends on lqs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lqs_sort
    import lqs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lqs_cfg_t           cfg,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] first_x,
    input  wire logic signed [31:0] first_y,
    input  wire logic signed [31:0] second_x,
    input  wire logic signed [31:0] second_y,
    input  wire logic [24:0]        first_recip_w,
    input  wire logic [31:0]        first_view_z,
    input  wire logic [23:0]        color_rgb,
    input  wire logic [31:0]        spec_word,
    output logic                    s_valid,
    input  wire logic               s_ready,
    output lqs_sorted_t             s_data
);

    logic               v1_reg, v1_next;
    logic signed [31:0] ax1_reg, ay1_reg, bx1_reg, by1_reg;
    logic signed [32:0] dx1_reg, dy1_reg;
    logic [56:0]        prod1_reg;
    logic [24:0]        rw1_reg;
    logic [31:0]        color1_reg, spec1_reg;

    logic               v2_reg, v2_next;
    lqs_sorted_t        s2_reg, s2_next;

    logic               ready1, ready2;
    logic               clip_ok;
    logic [31:0]        mul_a;
    logic [32:0]        adx, ady;
    logic               swap;
    logic signed [41:0] d_wide;

    assign ready2   = !v2_reg || s_ready;
    assign ready1   = !v1_reg || ready2;
    assign in_ready = ready1;

    // drop lines whose clip window is under one pixel
    assign clip_ok =
        (($signed({cfg.clip_bottom[31], cfg.clip_bottom})
          - $signed({cfg.clip_top[31], cfg.clip_top})) >= 33'sd65536) &&
        (($signed({cfg.clip_right[31], cfg.clip_right})
          - $signed({cfg.clip_left[31], cfg.clip_left})) >= 33'sd65536);

    assign mul_a = (cfg.depth_mode == DEPTH_VIEWZ) ? first_view_z : {7'd0, first_recip_w};

    always_comb
    begin
        v1_next = v1_reg;
        if (ready1)
        begin
            v1_next = in_valid && clip_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && ready1)
        begin
            ax1_reg    <= first_x;
            ay1_reg    <= first_y;
            bx1_reg    <= second_x;
            by1_reg    <= second_y;
            dx1_reg    <= $signed({second_x[31], second_x}) - $signed({first_x[31], first_x});
            dy1_reg    <= $signed({second_y[31], second_y}) - $signed({first_y[31], first_y});
            prod1_reg  <= 57'(mul_a) * 57'(cfg.depth_scale);
            rw1_reg    <= first_recip_w;
            color1_reg <= {cfg.alpha, color_rgb};
            spec1_reg  <= spec_word;
        end
    end

    always_comb
    begin
        adx  = dx1_reg[32] ? 33'(-dx1_reg) : 33'(dx1_reg);
        ady  = dy1_reg[32] ? 33'(-dy1_reg) : 33'(dy1_reg);
        case (cfg.depth_mode)
            DEPTH_CONST: d_wide = $signed({17'd0, cfg.depth_bias});
            DEPTH_VIEWZ: d_wide = $signed({1'b0, prod1_reg[56:16]});
            default:     d_wide = $signed({17'd0, cfg.depth_bias})
                                  - $signed({9'd0, prod1_reg[56:24]});
        endcase

        s2_next.xmajor = (ady <= adx);
        swap = s2_next.xmajor ? (ax1_reg > bx1_reg) : (ay1_reg > by1_reg);
        s2_next.ax = swap ? bx1_reg : ax1_reg;
        s2_next.ay = swap ? by1_reg : ay1_reg;
        s2_next.bx = swap ? ax1_reg : bx1_reg;
        s2_next.by = swap ? ay1_reg : by1_reg;
        if (d_wide < 42'sd0)
        begin
            s2_next.depth = 25'd0;
        end
        else if (d_wide > $signed({17'd0, DEPTH_ONE}))
        begin
            s2_next.depth = DEPTH_ONE;
        end
        else
        begin
            s2_next.depth = d_wide[24:0];
        end
        s2_next.rw    = rw1_reg;
        s2_next.color = color1_reg;
        s2_next.spec  = spec1_reg;
    end

    always_comb
    begin
        v2_next = v2_reg;
        if (ready2)
        begin
            v2_next = v1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg && ready2)
        begin
            s2_reg <= s2_next;
        end
    end

    assign s_valid = v2_reg;
    assign s_data  = s2_reg;

endmodule

`default_nettype wire

>>> rtl/lqs_clamp.sv
// lqs_clamp: third pipeline stage - shrink the clip window on the minor axis,
// clamp the half-pixel-centred endpoints and add the pixel offset. Depends on lqs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lqs_clamp
    import lqs_pkg::*;
#(
    parameter int X_OFFSET = LQS_X_OFFSET,
    parameter int Y_OFFSET = LQS_Y_OFFSET
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire lqs_cfg_t    cfg,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire lqs_sorted_t s_data,
    output logic             q_valid,
    input  wire logic        q_ready,
    output lqs_quad_t        q_data
);

    localparam logic signed [33:0] X_OFS  = 34'(X_OFFSET * ONE_PIXEL);
    localparam logic signed [33:0] Y_OFS  = 34'(Y_OFFSET * ONE_PIXEL);
    localparam logic signed [32:0] HALF33 = 33'(HALF_PIXEL);

    logic               v_reg, v_next;
    lqs_quad_t          q_reg, q_next;
    logic signed [32:0] lft, rgt, top, bot;

    assign s_ready = !v_reg || q_ready;

    always_comb
    begin
        lft = $signed({cfg.clip_left[31], cfg.clip_left});
        rgt = $signed({cfg.clip_right[31], cfg.clip_right});
        top = $signed({cfg.clip_top[31], cfg.clip_top});
        bot = $signed({cfg.clip_bottom[31], cfg.clip_bottom});
        if (s_data.xmajor)
        begin
            top = top + HALF33;
            bot = bot - HALF33;
        end
        else
        begin
            lft = lft + HALF33;
            rgt = rgt - HALF33;
        end

        q_next.xmajor = s_data.xmajor;
        q_next.x0 = 34'(clamp_s33($signed({s_data.ax[31], s_data.ax}) + HALF33, lft, rgt))
                    + X_OFS;
        q_next.x1 = 34'(clamp_s33($signed({s_data.bx[31], s_data.bx}) + HALF33, lft, rgt))
                    + X_OFS;
        q_next.y0 = 34'(clamp_s33($signed({s_data.ay[31], s_data.ay}) + HALF33, top, bot))
                    + Y_OFS;
        q_next.y1 = 34'(clamp_s33($signed({s_data.by[31], s_data.by}) + HALF33, top, bot))
                    + Y_OFS;
        q_next.depth = s_data.depth;
        q_next.rw    = s_data.rw;
        q_next.color = s_data.color;
        q_next.spec  = s_data.spec;
    end

    always_comb
    begin
        v_next = v_reg;
        if (s_ready)
        begin
            v_next = s_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            q_reg <= q_next;
        end
    end

    assign q_valid = v_reg;
    assign q_data  = q_reg;

endmodule

`default_nettype wire

>>> rtl/lqs_emit.sv
// lqs_emit: quad output register - hold one quad and send its four vertices,
// one per cycle while out_ready is high, with minor-axis half-pixel offsets and saturation. Depends on lqs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lqs_emit
    import lqs_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         q_valid,
    output logic              q_ready,
    input  wire lqs_quad_t    q_data,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic signed [31:0] vertex_x,
    output logic signed [31:0] vertex_y,
    output logic [24:0]       depth,
    output logic [24:0]       recip_w,
    output logic [31:0]       color_argb,
    output logic [31:0]       specular,
    output logic              last
);

    localparam logic signed [34:0] HALF35 = 35'(HALF_PIXEL);

    logic               qv_reg, qv_next;
    lqs_quad_t          quad_reg;
    logic [1:0]         cnt_reg, cnt_next;
    logic               is_last;
    logic               plus;
    logic signed [34:0] bx, by, ofs;

    assign is_last = (cnt_reg == 2'd3);
    assign q_ready = !qv_reg || (out_ready && is_last);

    always_comb
    begin
        qv_next  = qv_reg;
        cnt_next = cnt_reg;
        if (q_ready)
        begin
            qv_next  = q_valid;
            cnt_next = 2'd0;
        end
        else if (out_ready)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qv_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            qv_reg  <= qv_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready)
        begin
            quad_reg <= q_data;
        end
    end

    always_comb
    begin
        bx   = cnt_reg[1] ? 35'(quad_reg.x1) : 35'(quad_reg.x0);
        by   = cnt_reg[1] ? 35'(quad_reg.y1) : 35'(quad_reg.y0);
        // x major: +half on vertices 0 and 3; y major: +half on vertices 1 and 2
        plus = (cnt_reg[0] ^ cnt_reg[1]) ^ quad_reg.xmajor;
        ofs  = plus ? HALF35 : -HALF35;
        if (quad_reg.xmajor)
        begin
            by = by + ofs;
        end
        else
        begin
            bx = bx + ofs;
        end
    end

    assign out_valid  = qv_reg;
    assign vertex_x   = $signed(sat_s32(bx));
    assign vertex_y   = $signed(sat_s32(by));
    assign depth      = quad_reg.depth;
    assign recip_w    = quad_reg.rw;
    assign color_argb = quad_reg.color;
    assign specular   = quad_reg.spec;
    assign last       = is_last;

endmodule

`default_nettype wire

>>> rtl/line_quad_setup.sv
// line_quad_setup: top level - configuration registers and the line-to-quad pipeline.
// Depends on lqs_pkg, lqs_sort, lqs_clamp and lqs_emit.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   first_x .. spec_word, one line
//   out      output     out_valid / out_ready vertex_x .. last, one vertex
//   cfg      input      cfg_we                cfg_index, cfg_data
//
// A line passes three register stages to reach the quad register, then leaves as
// four vertices; the quad register takes a new quad as its last vertex is taken.
// Stages ahead of it keep taking lines while it drains, until they are all full.
// rst_n clears all valid bits and loads the register defaults.
// A stalled out_ready holds every stage that is full; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module line_quad_setup
    import lqs_pkg::*;
#(
    parameter int X_OFFSET = LQS_X_OFFSET,
    parameter int Y_OFFSET = LQS_Y_OFFSET
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic signed [31:0]    first_x,
    input  wire logic signed [31:0]    first_y,
    input  wire logic signed [31:0]    second_x,
    input  wire logic signed [31:0]    second_y,
    input  wire logic [24:0]           first_recip_w,
    input  wire logic [31:0]           first_view_z,
    input  wire logic [23:0]           color_rgb,
    input  wire logic [31:0]           spec_word,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic signed [31:0]         vertex_x,
    output logic signed [31:0]         vertex_y,
    output logic [24:0]                depth,
    output logic [24:0]                recip_w,
    output logic [31:0]                color_argb,
    output logic [31:0]                specular,
    output logic                       last
);

    lqs_cfg_t    cfg_reg, cfg_next;
    logic        s_valid, s_ready, q_valid, q_ready;
    lqs_sorted_t s_data;
    lqs_quad_t   q_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CLIP_LEFT:   cfg_next.clip_left   = $signed(cfg_data);
                REG_CLIP_RIGHT:  cfg_next.clip_right  = $signed(cfg_data);
                REG_CLIP_TOP:    cfg_next.clip_top    = $signed(cfg_data);
                REG_CLIP_BOTTOM: cfg_next.clip_bottom = $signed(cfg_data);
                REG_DEPTH_MODE:  cfg_next.depth_mode  = cfg_data[1:0];
                REG_DEPTH_BIAS:  cfg_next.depth_bias  = cfg_data[24:0];
                REG_DEPTH_SCALE: cfg_next.depth_scale = cfg_data[24:0];
                REG_ALPHA:       cfg_next.alpha       = cfg_data[7:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clip_left   <= $signed(RST_CLIP_LEFT);
            cfg_reg.clip_right  <= $signed(RST_CLIP_RIGHT);
            cfg_reg.clip_top    <= $signed(RST_CLIP_TOP);
            cfg_reg.clip_bottom <= $signed(RST_CLIP_BOTTOM);
            cfg_reg.depth_mode  <= RST_DEPTH_MODE;
            cfg_reg.depth_bias  <= RST_DEPTH_BIAS;
            cfg_reg.depth_scale <= RST_DEPTH_SCALE;
            cfg_reg.alpha       <= RST_ALPHA;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lqs_sort u_sort (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .first_x       (first_x),
        .first_y       (first_y),
        .second_x      (second_x),
        .second_y      (second_y),
        .first_recip_w (first_recip_w),
        .first_view_z  (first_view_z),
        .color_rgb     (color_rgb),
        .spec_word     (spec_word),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data)
    );

    lqs_clamp #(
        .X_OFFSET (X_OFFSET),
        .Y_OFFSET (Y_OFFSET)
    ) u_clamp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data)
    );

    lqs_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_data     (q_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .vertex_x   (vertex_x),
        .vertex_y   (vertex_y),
        .depth      (depth),
        .recip_w    (recip_w),
        .color_argb (color_argb),
        .specular   (specular),
        .last       (last)
    );

endmodule

`default_nettype wire

>>> rtl/lqs_checker.sv
// lqs_checker: port-level assertions for line_quad_setup, attached by bind.
// Depends on lqs_pkg and the line_quad_setup port list.
`timescale 1ns / 1ps
`default_nettype none

module lqs_checker
    import lqs_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] vertex_x,
    input wire logic [31:0] vertex_y,
    input wire logic [24:0] depth,
    input wire logic [24:0] recip_w,
    input wire logic [31:0] color_argb,
    input wire logic        last
);

    // hold the vertex while the request stalls
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(vertex_x) && $stable(vertex_y)
                                    && $stable(last))
        else $error("vertex changed while stalled");

    a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> depth <= DEPTH_ONE)
        else $error("depth above 1.0");

    a_quad_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last |=> !(out_valid && last))
        else $error("quad end not followed by a new quad");

    a_quad_shared: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid && $stable(depth) && $stable(recip_w)
                                            && $stable(color_argb))
        else $error("shared vertex data changed inside a quad");

endmodule

bind line_quad_setup lqs_checker u_lqs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .vertex_x   (vertex_x),
    .vertex_y   (vertex_y),
    .depth      (depth),
    .recip_w    (recip_w),
    .color_argb (color_argb),
    .last       (last)
);

`default_nettype wire
